/* sv/epd_pkg.sv */
package epd_pkg;

    // Phase of the refresh sequence, as reported in each result.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PON  = 2'd1,
        PH_XFER = 2'd2,
        PH_POFF = 2'd3
    } phase_t;

    // Kind of an input transaction.
    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_START    = 2'd1,
        KIND_XFER_DONE = 2'd2,
        KIND_SHUTDOWN = 2'd3
    } kind_t;

    // Action driven by a sub-step.
    typedef enum logic [3:0] {
        ACT_NONE        = 4'd0,
        ACT_PINS_ON     = 4'd1,
        ACT_WAKEUP_HIGH = 4'd2,
        ACT_RAIL_REGS   = 4'd3,
        ACT_PWRUP_HIGH  = 4'd4,
        ACT_VCOM_OE     = 4'd5,
        ACT_VCOM_LOW    = 4'd6,
        ACT_PWRUP_LOW   = 4'd7,
        ACT_RAILS_OFF   = 4'd8,
        ACT_PINS_LOW    = 4'd9,
        ACT_CLOCK_STOP  = 4'd10,
        ACT_EMERG_OFF   = 4'd11
    } action_t;

    // Sub-step codes of the power-on phase.
    localparam logic [3:0] PON_PINS    = 4'd0;
    localparam logic [3:0] PON_WAKEUP  = 4'd1;
    localparam logic [3:0] PON_DELAY   = 4'd2;
    localparam logic [3:0] PON_RAILS   = 4'd3;
    localparam logic [3:0] PON_PWRUP   = 4'd4;
    localparam logic [3:0] PON_POLL    = 4'd5;
    localparam logic [3:0] PON_VCOM    = 4'd6;

    // Sub-step codes of the power-off phase.
    localparam logic [3:0] POFF_VCOM   = 4'd0;
    localparam logic [3:0] POFF_PWRUP  = 4'd1;
    localparam logic [3:0] POFF_WAIT   = 4'd2;
    localparam logic [3:0] POFF_RAILS  = 4'd3;
    localparam logic [3:0] POFF_PINS   = 4'd4;
    localparam logic [3:0] POFF_CLOCK  = 4'd5;

    // Configuration register indexes.
    localparam logic [1:0] REG_PG_EXPECTED = 2'd0;
    localparam logic [1:0] REG_WAKEUP_MS   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_MS  = 2'd2;

    // Register widths and reset values.
    localparam int PG_W       = 8;
    localparam int WAKE_W     = 8;
    localparam int TMO_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [PG_W-1:0]   PG_EXPECTED_RST = 8'd250;
    localparam logic [WAKE_W-1:0] WAKEUP_MS_RST   = 8'd5;
    localparam logic [TMO_W-1:0]  TIMEOUT_MS_RST  = 16'd250;

endpackage

/* sv/epd_power_update_sequencer.sv */
// An accepted input transaction passes through the input register and then the result
// register. Throughput: one transaction per cycle while the result side is not stalled;
// each of the two holds one item, and a step does at most one subtract and compare.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle, clears
// both time marks and loads the configuration registers with their defaults.
module epd_power_update_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [epd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [epd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [39:0]                       s_axis_tdata,  // now_ms[31:0], power_good[39:32]
    input  logic [1:0]                        s_axis_tuser,  // kind[1:0]
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata   // phase[1:0], action[5:2],
                                                             // good_timeout[6], refresh_done[7]
);

    localparam int TW = epd_pkg::TIME_W;

    // Configuration registers
    logic [epd_pkg::PG_W-1:0]   pg_expected_reg;
    logic [epd_pkg::WAKE_W-1:0] wakeup_ms_reg;
    logic [epd_pkg::TMO_W-1:0]  timeout_ms_reg;

    // Input register
    logic                       in_valid_reg;
    epd_pkg::kind_t             in_kind_reg;
    logic [TW-1:0]              in_now_reg;
    logic [epd_pkg::PG_W-1:0]   in_pg_reg;

    // Sequencer state
    epd_pkg::phase_t            phase_reg, phase_next;
    logic [3:0]                 sub_step_reg, sub_step_next;
    logic [TW-1:0]              mark_time_reg, mark_time_next;
    logic [TW-1:0]              rails_start_reg, rails_start_next;

    // Result register
    logic                       out_valid_reg;
    epd_pkg::phase_t            out_phase_reg;
    epd_pkg::action_t           out_action_reg;
    logic                       out_tmo_reg;
    logic                       out_done_reg;

    // Result of the current step
    epd_pkg::action_t           act;
    logic                       tmo;
    logic                       done;
    logic [TW-1:0]              since_mark;
    logic [TW-1:0]              since_rails;
    logic                       advance;

    // An item moves on when the result register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_done_reg, out_tmo_reg, out_action_reg, out_phase_reg};

    // Elapsed times, wrapping modulo 2^32.
    assign since_mark  = in_now_reg - mark_time_reg;
    assign since_rails = in_now_reg - rails_start_reg;

    // Step logic for one transaction.
    always_comb
    begin
        phase_next       = phase_reg;
        sub_step_next    = sub_step_reg;
        mark_time_next   = mark_time_reg;
        rails_start_next = rails_start_reg;
        act              = epd_pkg::ACT_NONE;
        tmo              = 1'b0;
        done             = 1'b0;

        case (in_kind_reg)
            epd_pkg::KIND_TICK:
            begin
                if (phase_reg == epd_pkg::PH_PON)
                begin
                    case (sub_step_reg)
                        epd_pkg::PON_PINS:
                        begin
                            act           = epd_pkg::ACT_PINS_ON;
                            sub_step_next = epd_pkg::PON_WAKEUP;
                        end
                        epd_pkg::PON_WAKEUP:
                        begin
                            act            = epd_pkg::ACT_WAKEUP_HIGH;
                            mark_time_next = in_now_reg;
                            sub_step_next  = epd_pkg::PON_DELAY;
                        end
                        epd_pkg::PON_DELAY:
                        begin
                            if (since_mark >= TW'(wakeup_ms_reg))
                            begin
                                sub_step_next = epd_pkg::PON_RAILS;
                            end
                        end
                        epd_pkg::PON_RAILS:
                        begin
                            act              = epd_pkg::ACT_RAIL_REGS;
                            rails_start_next = in_now_reg;
                            sub_step_next    = epd_pkg::PON_PWRUP;
                        end
                        epd_pkg::PON_PWRUP:
                        begin
                            act           = epd_pkg::ACT_PWRUP_HIGH;
                            sub_step_next = epd_pkg::PON_POLL;
                        end
                        epd_pkg::PON_POLL:
                        begin
                            // Wait for power-good, giving up after the timeout.
                            if (in_pg_reg == pg_expected_reg)
                            begin
                                sub_step_next = epd_pkg::PON_VCOM;
                            end
                            else if (since_rails > TW'(timeout_ms_reg))
                            begin
                                tmo           = 1'b1;
                                sub_step_next = epd_pkg::PON_VCOM;
                            end
                        end
                        epd_pkg::PON_VCOM:
                        begin
                            act           = epd_pkg::ACT_VCOM_OE;
                            phase_next    = epd_pkg::PH_XFER;
                            sub_step_next = epd_pkg::PON_PINS;
                        end
                        default:
                        begin
                            sub_step_next = epd_pkg::PON_PINS;
                        end
                    endcase
                end
                else if (phase_reg == epd_pkg::PH_POFF)
                begin
                    case (sub_step_reg)
                        epd_pkg::POFF_VCOM:
                        begin
                            act           = epd_pkg::ACT_VCOM_LOW;
                            sub_step_next = epd_pkg::POFF_PWRUP;
                        end
                        epd_pkg::POFF_PWRUP:
                        begin
                            act            = epd_pkg::ACT_PWRUP_LOW;
                            mark_time_next = in_now_reg;
                            sub_step_next  = epd_pkg::POFF_WAIT;
                        end
                        epd_pkg::POFF_WAIT:
                        begin
                            // Wait for the rails to fall, or for the timeout.
                            if ((in_pg_reg == '0) || (since_mark > TW'(timeout_ms_reg)))
                            begin
                                sub_step_next = epd_pkg::POFF_RAILS;
                            end
                        end
                        epd_pkg::POFF_RAILS:
                        begin
                            act           = epd_pkg::ACT_RAILS_OFF;
                            sub_step_next = epd_pkg::POFF_PINS;
                        end
                        epd_pkg::POFF_PINS:
                        begin
                            act           = epd_pkg::ACT_PINS_LOW;
                            sub_step_next = epd_pkg::POFF_CLOCK;
                        end
                        epd_pkg::POFF_CLOCK:
                        begin
                            act           = epd_pkg::ACT_CLOCK_STOP;
                            phase_next    = epd_pkg::PH_IDLE;
                            sub_step_next = epd_pkg::POFF_VCOM;
                            done          = 1'b1;
                        end
                        default:
                        begin
                            sub_step_next = epd_pkg::POFF_VCOM;
                        end
                    endcase
                end
            end
            epd_pkg::KIND_START:
            begin
                if (phase_reg == epd_pkg::PH_IDLE)
                begin
                    phase_next       = epd_pkg::PH_PON;
                    sub_step_next    = epd_pkg::PON_PINS;
                    mark_time_next   = '0;
                    rails_start_next = '0;
                end
            end
            epd_pkg::KIND_XFER_DONE:
            begin
                if (phase_reg == epd_pkg::PH_XFER)
                begin
                    phase_next    = epd_pkg::PH_POFF;
                    sub_step_next = epd_pkg::POFF_VCOM;
                end
            end
            default:
            begin
                // Shutdown while busy forces the sequencer back to idle.
                if (phase_reg != epd_pkg::PH_IDLE)
                begin
                    phase_next    = epd_pkg::PH_IDLE;
                    sub_step_next = epd_pkg::PON_PINS;
                    act           = epd_pkg::ACT_EMERG_OFF;
                    done          = 1'b1;
                end
            end
        endcase
    end

    // Configuration writes; indexes beyond the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pg_expected_reg <= epd_pkg::PG_EXPECTED_RST;
            wakeup_ms_reg   <= epd_pkg::WAKEUP_MS_RST;
            timeout_ms_reg  <= epd_pkg::TIMEOUT_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                epd_pkg::REG_PG_EXPECTED: pg_expected_reg <= cfg_data[epd_pkg::PG_W-1:0];
                epd_pkg::REG_WAKEUP_MS:   wakeup_ms_reg   <= cfg_data[epd_pkg::WAKE_W-1:0];
                epd_pkg::REG_TIMEOUT_MS:  timeout_ms_reg  <= cfg_data[epd_pkg::TMO_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input register payload, loaded on each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_kind_reg <= epd_pkg::kind_t'(s_axis_tuser);
            in_now_reg  <= s_axis_tdata[TW-1:0];
            in_pg_reg   <= s_axis_tdata[TW+epd_pkg::PG_W-1:TW];
        end
    end

    // Sequencer state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= epd_pkg::PH_IDLE;
            sub_step_reg    <= epd_pkg::PON_PINS;
            mark_time_reg   <= '0;
            rails_start_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg       <= phase_next;
                sub_step_reg    <= sub_step_next;
                mark_time_reg   <= mark_time_next;
                rails_start_reg <= rails_start_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_phase_reg  <= phase_next;
            out_action_reg <= act;
            out_tmo_reg    <= tmo;
            out_done_reg   <= done;
        end
    end

endmodule

/* tb/tb_epd_power_update_sequencer.sv */
module tb_epd_power_update_sequencer;

    // Register index that decodes to nothing and must leave every setting alone.
    localparam logic [epd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Cycles without any transaction on either side before the run is abandoned.
    localparam int STALL_LIMIT = 2000;

    // The scoreboard keeps its own copy of the sequencer state and settings.
    // Each accepted event is stepped through it, and the resulting result is queued.
    class refresh_scoreboard;
        epd_pkg::phase_t            seq_phase;
        logic [3:0]                 sub_step;
        logic [31:0]                mark_ms;
        logic [31:0]                rails_on_ms;
        logic [epd_pkg::PG_W-1:0]   pg_expected;
        logic [epd_pkg::WAKE_W-1:0] wakeup_ms;
        logic [epd_pkg::TMO_W-1:0]  timeout_ms;
        logic [7:0]                 pending_results[$];
        int                         errors;

        function new();
            seq_phase   = epd_pkg::PH_IDLE;
            sub_step    = epd_pkg::PON_PINS;
            mark_ms     = '0;
            rails_on_ms = '0;
            pg_expected = epd_pkg::PG_EXPECTED_RST;
            wakeup_ms   = epd_pkg::WAKEUP_MS_RST;
            timeout_ms  = epd_pkg::TIMEOUT_MS_RST;
            errors      = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Only the bits within each register's width are kept.
        function void write_reg(logic [epd_pkg::CFG_IDX_W-1:0] index,
                                logic [epd_pkg::CFG_DATA_W-1:0] data);
            case (index)
                epd_pkg::REG_PG_EXPECTED: pg_expected = data[epd_pkg::PG_W-1:0];
                epd_pkg::REG_WAKEUP_MS:   wakeup_ms   = data[epd_pkg::WAKE_W-1:0];
                epd_pkg::REG_TIMEOUT_MS:  timeout_ms  = data[epd_pkg::TMO_W-1:0];
                default: ;
            endcase
        endfunction

        function void accept_event(epd_pkg::kind_t kind, logic [31:0] now, logic [7:0] pg);
            epd_pkg::action_t act;
            logic             tmo;
            logic             done;
            logic [31:0]      elapsed;
            act  = epd_pkg::ACT_NONE;
            tmo  = 1'b0;
            done = 1'b0;
            case (kind)
                epd_pkg::KIND_TICK:
                begin
                    if (seq_phase == epd_pkg::PH_PON)
                    begin
                        case (sub_step)
                            epd_pkg::PON_PINS:
                            begin
                                act      = epd_pkg::ACT_PINS_ON;
                                sub_step = epd_pkg::PON_WAKEUP;
                            end
                            epd_pkg::PON_WAKEUP:
                            begin
                                act      = epd_pkg::ACT_WAKEUP_HIGH;
                                mark_ms  = now;
                                sub_step = epd_pkg::PON_DELAY;
                            end
                            epd_pkg::PON_DELAY:
                            begin
                                elapsed = now - mark_ms;
                                if (elapsed >= wakeup_ms)
                                    sub_step = epd_pkg::PON_RAILS;
                            end
                            epd_pkg::PON_RAILS:
                            begin
                                act         = epd_pkg::ACT_RAIL_REGS;
                                rails_on_ms = now;
                                sub_step    = epd_pkg::PON_PWRUP;
                            end
                            epd_pkg::PON_PWRUP:
                            begin
                                act      = epd_pkg::ACT_PWRUP_HIGH;
                                sub_step = epd_pkg::PON_POLL;
                            end
                            epd_pkg::PON_POLL:
                            begin
                                elapsed = now - rails_on_ms;
                                if (pg == pg_expected)
                                    sub_step = epd_pkg::PON_VCOM;
                                else if (elapsed > timeout_ms)
                                begin
                                    tmo      = 1'b1;
                                    sub_step = epd_pkg::PON_VCOM;
                                end
                            end
                            epd_pkg::PON_VCOM:
                            begin
                                act       = epd_pkg::ACT_VCOM_OE;
                                seq_phase = epd_pkg::PH_XFER;
                                sub_step  = epd_pkg::PON_PINS;
                            end
                            default: sub_step = epd_pkg::PON_PINS;
                        endcase
                    end
                    else if (seq_phase == epd_pkg::PH_POFF)
                    begin
                        case (sub_step)
                            epd_pkg::POFF_VCOM:
                            begin
                                act      = epd_pkg::ACT_VCOM_LOW;
                                sub_step = epd_pkg::POFF_PWRUP;
                            end
                            epd_pkg::POFF_PWRUP:
                            begin
                                act      = epd_pkg::ACT_PWRUP_LOW;
                                mark_ms  = now;
                                sub_step = epd_pkg::POFF_WAIT;
                            end
                            epd_pkg::POFF_WAIT:
                            begin
                                elapsed = now - mark_ms;
                                if (pg == 8'd0 || elapsed > timeout_ms)
                                    sub_step = epd_pkg::POFF_RAILS;
                            end
                            epd_pkg::POFF_RAILS:
                            begin
                                act      = epd_pkg::ACT_RAILS_OFF;
                                sub_step = epd_pkg::POFF_PINS;
                            end
                            epd_pkg::POFF_PINS:
                            begin
                                act      = epd_pkg::ACT_PINS_LOW;
                                sub_step = epd_pkg::POFF_CLOCK;
                            end
                            epd_pkg::POFF_CLOCK:
                            begin
                                act       = epd_pkg::ACT_CLOCK_STOP;
                                seq_phase = epd_pkg::PH_IDLE;
                                sub_step  = epd_pkg::POFF_VCOM;
                                done      = 1'b1;
                            end
                            default: sub_step = epd_pkg::POFF_VCOM;
                        endcase
                    end
                end
                epd_pkg::KIND_START:
                begin
                    // A start while a refresh is running is dropped.
                    if (seq_phase == epd_pkg::PH_IDLE)
                    begin
                        seq_phase   = epd_pkg::PH_PON;
                        sub_step    = epd_pkg::PON_PINS;
                        mark_ms     = '0;
                        rails_on_ms = '0;
                    end
                end
                epd_pkg::KIND_XFER_DONE:
                begin
                    if (seq_phase == epd_pkg::PH_XFER)
                    begin
                        seq_phase = epd_pkg::PH_POFF;
                        sub_step  = epd_pkg::POFF_VCOM;
                    end
                end
                default:
                begin
                    // Shutdown forces idle from any busy phase.
                    if (seq_phase != epd_pkg::PH_IDLE)
                    begin
                        seq_phase = epd_pkg::PH_IDLE;
                        sub_step  = epd_pkg::PON_PINS;
                        act       = epd_pkg::ACT_EMERG_OFF;
                        done      = 1'b1;
                    end
                end
            endcase
            pending_results.push_back({done, tmo, act, seq_phase});
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h, expected nothing", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("phase", int'(want[1:0]), int'(got[1:0]));
            compare_field("action", int'(want[5:2]), int'(got[5:2]));
            compare_field("good_timeout", int'(want[6]), int'(got[6]));
            compare_field("refresh_done", int'(want[7]), int'(got[7]));
        endfunction
    endclass

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           cfg_we        = 1'b0;
    logic [epd_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [epd_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [39:0]                    s_axis_tdata  = '0;  // now_ms[31:0], power_good[39:32]
    logic [1:0]                     s_axis_tuser  = '0;  // kind[1:0]
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [7:0]                     m_axis_tdata;        // phase[1:0], action[5:2],
                                                         // good_timeout[6], refresh_done[7]

    refresh_scoreboard sb;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                sent_count     = 0;
    int                stalled_cycles = 0;
    logic [31:0]       clock_ms       = 32'hFFFF_F000;

    epd_power_update_sequencer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // The result side stalls at random according to the current phase.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every transaction is seen here at the rising edge: events are stepped through
    // the scoreboard before results are checked, and idle stretches are counted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.accept_event(epd_pkg::kind_t'(s_axis_tuser), s_axis_tdata[31:0],
                                s_axis_tdata[39:32]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(epd_pkg::kind_t kind, logic [31:0] now, logic [7:0] pg);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {pg, now};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    // Holds the input back until every outstanding result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [epd_pkg::CFG_IDX_W-1:0] index,
                             logic [epd_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        sb.write_reg(index, data);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Random upper bits go into the narrow registers, and the unused index gets a write.
    task automatic configure(logic [7:0] pg, logic [7:0] wake, logic [15:0] tmo);
        write_reg(epd_pkg::REG_PG_EXPECTED, {8'($urandom_range(255)), pg});
        write_reg(epd_pkg::REG_WAKEUP_MS, {8'($urandom_range(255)), wake});
        write_reg(epd_pkg::REG_TIMEOUT_MS, tmo);
        write_reg(REG_UNUSED, 16'($urandom));
    endtask

    // Mostly short steps of time, now and then long jumps or a wholly new time.
    function automatic logic [31:0] step_ms();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return $urandom_range(10);
        else if (r < 88)
            return $urandom_range(300);
        else if (r < 98)
            return $urandom_range(70000);
        return $urandom;
    endfunction

    // Power-good bytes that let the polling steps finish often enough.
    function automatic logic [7:0] pick_pg();
        if (sb.seq_phase == epd_pkg::PH_PON && sb.sub_step == epd_pkg::PON_POLL
            && $urandom_range(99) < 45)
            return sb.pg_expected;
        if (sb.seq_phase == epd_pkg::PH_POFF && sb.sub_step == epd_pkg::POFF_WAIT
            && $urandom_range(99) < 40)
            return 8'd0;
        return 8'($urandom_range(255));
    endfunction

    task automatic tick_now(logic [7:0] pg);
        clock_ms = clock_ms + step_ms();
        send_item(epd_pkg::KIND_TICK, clock_ms, pg);
    endtask

    task automatic noise_item();
        send_item(epd_pkg::kind_t'($urandom_range(3)), $urandom, 8'($urandom_range(255)));
    endtask

    // One complete refresh, with a little noise mixed into the waits.
    task automatic run_refresh();
        int guard;
        send_item(epd_pkg::KIND_START, clock_ms, 8'($urandom_range(255)));
        guard = 0;
        while (sb.seq_phase == epd_pkg::PH_PON && guard < 400)
        begin
            guard++;
            if ($urandom_range(99) < 3)
                noise_item();
            else
                tick_now(pick_pg());
        end
        if (sb.seq_phase == epd_pkg::PH_XFER)
        begin
            repeat ($urandom_range(3))
            begin
                if ($urandom_range(1) == 0)
                    tick_now(pick_pg());
                else
                    send_item(epd_pkg::KIND_START, clock_ms, 8'($urandom_range(255)));
            end
            if ($urandom_range(99) < 4)
                send_item(epd_pkg::KIND_SHUTDOWN, clock_ms, 8'($urandom_range(255)));
            else
                send_item(epd_pkg::KIND_XFER_DONE, clock_ms, 8'($urandom_range(255)));
        end
        guard = 0;
        while (sb.seq_phase == epd_pkg::PH_POFF && guard < 400)
        begin
            guard++;
            if ($urandom_range(99) < 3)
                noise_item();
            else
                tick_now(pick_pg());
        end
        if (sb.seq_phase != epd_pkg::PH_IDLE)
            send_item(epd_pkg::KIND_SHUTDOWN, clock_ms, 8'($urandom_range(255)));
    endtask

    initial
    begin
        int phase_start;
        bit paused;
        sb = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed refresh with the reset settings, time wrapping across the wakeup wait.
        send_item(epd_pkg::KIND_TICK, 32'h0000_0000, 8'h00);
        send_item(epd_pkg::KIND_SHUTDOWN, 32'h0000_0000, 8'h00);
        send_item(epd_pkg::KIND_XFER_DONE, 32'h0000_0000, 8'h00);
        send_item(epd_pkg::KIND_START, 32'hFFFF_FFFF, 8'hFF);
        send_item(epd_pkg::KIND_START, 32'hFFFF_FFFF, 8'hFF);
        send_item(epd_pkg::KIND_TICK, 32'hFFFF_FFFD, 8'h00);
        send_item(epd_pkg::KIND_TICK, 32'hFFFF_FFFE, 8'h00);
        send_item(epd_pkg::KIND_TICK, 32'h0000_0002, 8'h00);
        send_item(epd_pkg::KIND_TICK, 32'h0000_0003, 8'h00);
        send_item(epd_pkg::KIND_TICK, 32'h0000_0003, 8'h00);
        send_item(epd_pkg::KIND_TICK, 32'h0000_0004, 8'h00);
        send_item(epd_pkg::KIND_TICK, 32'h0000_00FD, 8'hF9);
        send_item(epd_pkg::KIND_TICK, 32'h0000_00FD, 8'hFA);
        send_item(epd_pkg::KIND_TICK, 32'h0000_00FE, 8'h00);
        send_item(epd_pkg::KIND_TICK, 32'h0000_00FF, 8'hFF);
        send_item(epd_pkg::KIND_XFER_DONE, 32'h0000_0100, 8'h00);
        send_item(epd_pkg::KIND_TICK, 32'h0000_0100, 8'h00);
        send_item(epd_pkg::KIND_TICK, 32'h0000_0064, 8'hFF);
        send_item(epd_pkg::KIND_TICK, 32'h0000_015E, 8'h55);
        send_item(epd_pkg::KIND_TICK, 32'h0000_015E, 8'h00);
        send_item(epd_pkg::KIND_TICK, 32'h0000_0160, 8'h00);
        send_item(epd_pkg::KIND_TICK, 32'h0000_0161, 8'h00);
        send_item(epd_pkg::KIND_TICK, 32'h0000_0162, 8'h00);
        send_item(epd_pkg::KIND_START, 32'h0000_0163, 8'h00);
        send_item(epd_pkg::KIND_SHUTDOWN, 32'h0000_0164, 8'h00);

        // Random refreshes over several settings and idling patterns.
        for (int p = 0; p < 5; p++)
        begin
            drain_results();
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    configure(8'd0, 8'd0, 16'd0);
                end
                1:
                begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                    configure(8'd255, 8'd255, 16'd65535);
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                    configure(8'($urandom_range(255)), 8'($urandom_range(20)),
                              16'($urandom_range(400)));
                end
                3:
                begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                    configure(8'($urandom_range(255)), 8'($urandom_range(1, 10)),
                              16'($urandom_range(50)));
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                              16'($urandom_range(1000)));
                end
            endcase
            phase_start = sent_count;
            paused      = 1'b0;
            while (sent_count - phase_start < 315)
            begin
                if (!paused && sent_count - phase_start > 150)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 85)
                    run_refresh();
                else
                    repeat ($urandom_range(1, 5)) noise_item();
            end
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
